### hdl/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg: shared types and constants for the button debouncer
// Per-button state entry, phase and event codes, register indexes and sizes.
// ----------------------------------------------------------------------------
package bdh_pkg;

    localparam int BUTTONS     = 6;
    localparam int BTN_IW      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int PIN_W       = 6;
    localparam int TICK_W      = 10;
    localparam int CFG_W       = 10;
    localparam int OUT_IDX_W   = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [TICK_W-1:0] TICK_MAX       = {TICK_W{1'b1}};
    localparam logic [CFG_W-1:0]  DEBOUNCE_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0]  HOLD_RESET     = CFG_W'(15);

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_HOLD    = 2'd1,
        EV_RELEASE = 2'd2
    } t_evcode;

    typedef enum logic [0:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_HOLD     = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_phase              phase;
        logic [TICK_W-1:0]   ticks;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{phase: PH_RELEASED, ticks: '0};

    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        t_evcode              code;
    } t_event;

    typedef struct packed {
        t_entry  entry;
        logic    ev;
        t_evcode code;
    } t_step_res;

    // Button number as carried on the output: the low bits of the index.
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [BTN_IW-1:0] idx);
        logic [BTN_IW+OUT_IDX_W-1:0] w;
        w = {{OUT_IDX_W{1'b0}}, idx};
        return w[OUT_IDX_W-1:0];
    endfunction

endpackage

### hdl/bdh_state_mem.sv
// ----------------------------------------------------------------------------
// bdh_state_mem: per-button state memory
// One write and one registered read per cycle, with valid bits for reset and
// write-to-read forwarding when both ports address the same entry.
// ----------------------------------------------------------------------------
module bdh_state_mem
    import bdh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [BTN_IW-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [BTN_IW-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    output t_entry            o_rd_data
);

    t_entry               r_mem [BUTTONS];
    logic [BUTTONS-1:0]   r_valid;
    t_entry               r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // An entry never written since reset reads as released with a zero count.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= ENTRY_RESET;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bdh_step.sv
// ----------------------------------------------------------------------------
// bdh_step: per-button phase update
// Works out the next phase and count of one button and the event it gives.
// ----------------------------------------------------------------------------
module bdh_step
    import bdh_pkg::*;
(
    input  t_entry            i_entry,
    input  logic              i_pressed,
    input  logic [CFG_W-1:0]  i_debounce,
    input  logic [CFG_W-1:0]  i_hold,
    output t_step_res         o_res
);

    logic [TICK_W-1:0] w_inc;

    always_comb begin
        w_inc = (i_entry.ticks < TICK_MAX) ? i_entry.ticks + 1'b1 : i_entry.ticks;

        o_res.entry = i_entry;
        o_res.ev    = 1'b0;
        o_res.code  = EV_PRESS;

        case (i_entry.phase)
            PH_DEBOUNCE: begin
                if (!i_pressed) begin
                    o_res.entry.phase = PH_RELEASED;
                    o_res.ev          = (i_entry.ticks > i_debounce);
                    o_res.code        = EV_PRESS;
                end else begin
                    o_res.entry.ticks = w_inc;
                    if (w_inc > i_hold) begin
                        o_res.entry.phase = PH_HELD;
                        o_res.ev          = 1'b1;
                        o_res.code        = EV_HOLD;
                    end
                end
            end
            PH_HELD: begin
                if (!i_pressed) begin
                    o_res.entry.phase = PH_RELEASED;
                    o_res.ev          = 1'b1;
                    o_res.code        = EV_RELEASE;
                end
            end
            default: begin
                o_res.entry.phase = PH_RELEASED;
                if (i_pressed) begin
                    o_res.entry.phase = PH_DEBOUNCE;
                    o_res.entry.ticks = '0;
                end
            end
        endcase
    end

endmodule

### hdl/bdh_evt_out.sv
// ----------------------------------------------------------------------------
// bdh_evt_out: event holding stage and output register
// Keeps the newest event back until it is known whether it ends its tick,
// then passes it to the master-side register, with the last flag set only
// if it closes its tick.
module bdh_evt_out
    import bdh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_event                i_event,
    input  logic                  i_end,
    output logic                  o_can_take,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output t_event                o_event,
    output logic                  o_last
);

    logic   r_h_valid, n_h_valid;
    logic   r_h_final, n_h_final;
    t_event r_h_evt,   n_h_evt;
    logic   r_o_valid, n_o_valid;
    t_event r_o_evt,   n_o_evt;
    logic   r_o_last,  n_o_last;

    logic   w_o_free;
    logic   w_h_move;

    always_comb begin
        w_o_free = !r_o_valid || i_tready;
        // The held event leaves once it is known to close its tick, or when a
        // newer event of the same tick displaces it.
        w_h_move = r_h_valid && w_o_free && (r_h_final || i_push);

        n_o_valid = r_o_valid;
        n_o_evt   = r_o_evt;
        n_o_last  = r_o_last;
        if (w_h_move) begin
            n_o_valid = 1'b1;
            n_o_evt   = r_h_evt;
            n_o_last  = r_h_final;
        end else if (i_tready) begin
            n_o_valid = 1'b0;
        end

        n_h_valid = r_h_valid;
        n_h_final = r_h_final;
        n_h_evt   = r_h_evt;
        if (i_push) begin
            n_h_valid = 1'b1;
            n_h_final = i_end;
            n_h_evt   = i_event;
        end else if (w_h_move) begin
            n_h_valid = 1'b0;
            n_h_final = 1'b0;
        end else if (i_end && r_h_valid) begin
            n_h_final = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_h_final <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_h_valid <= n_h_valid;
            r_h_final <= n_h_final;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_evt  <= n_h_evt;
        r_o_evt  <= n_o_evt;
        r_o_last <= n_o_last;
    end

    assign o_can_take = !r_h_valid || w_o_free;
    assign o_tvalid   = r_o_valid;
    assign o_event    = r_o_evt;
    assign o_last     = r_o_last;

endmodule

### hdl/button_debounce_hold_events.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_events: debouncer with press, hold and release events
// Scans the buttons of each tick through a state memory and emits events.
// ----------------------------------------------------------------------------
// Each slave-side transfer is one scan tick: tdata[5:0] holds the raw pin
// levels, active low, one bit per button. Every button is visited in turn,
// one a cycle unless the scan stalls, by reading its phase and count from the
// state memory, updating them and writing them back; the next tick is taken
// in the cycle its last button is read. The tick's transfer is registered,
// then each button's read is issued and registered in the state memory
// before its update; the newest event is then held back until a later event
// of the same tick or the end of the tick shows whether it carries tlast.
// Events leave in ascending button order on the master side, one a cycle
// while the receiver keeps up: tdata button index, tuser event code, tlast
// on the final event of the tick. A tick without events gives no transfer.
// When the receiver stalls, one event waits in the output register and one
// in the holding stage; the scan then stops at the next button that gives an
// event until space frees up, and the tick input stalls with it. Reset sets
// every button to released with a zero count and the limits to their
// defaults; no clearing pass is needed.
// The user must write the limits through the configuration port only while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module button_debounce_hold_events
    import bdh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // [5:0] pin_levels
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,  // [2:0] button_index
    output logic [1:0]            o_m_tuser,  // [1:0] event_code
    output logic                  o_m_tlast,  // last_event
    input  logic                  i_cfg_we,
    input  t_cfg_reg              i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0]  r_debounce;
    logic [CFG_W-1:0]  r_hold;

    logic              r_busy,  n_busy;
    logic [BTN_IW-1:0] r_cnt,   n_cnt;
    logic [PIN_W-1:0]  r_levels, n_levels;

    logic              r_b_valid, n_b_valid;
    logic [BTN_IW-1:0] r_b_idx,   n_b_idx;
    logic              r_b_pressed, n_b_pressed;
    logic              r_b_end,   n_b_end;

    logic [BUTTONS+PIN_W-1:0] w_lvl_ext;
    logic [BUTTONS-1:0]       w_pressed;
    logic                     w_issue;
    logic                     w_scan_last;
    logic                     w_accept;
    logic                     w_b_adv;
    logic                     w_can_take;
    t_entry                   w_rd_data;
    t_step_res                w_res;
    t_event                   w_new_evt;
    t_event                   w_out_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_hold     <= HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_HOLD:     r_hold     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Buttons beyond the pin field read as level low, that is pressed.
    assign w_lvl_ext = {{BUTTONS{1'b0}}, r_levels};
    assign w_pressed = ~w_lvl_ext[BUTTONS-1:0];

    always_comb begin
        w_b_adv     = r_b_valid && (!w_res.ev || w_can_take);
        w_issue     = r_busy && (!r_b_valid || w_b_adv);
        w_scan_last = (r_cnt == BTN_IW'(BUTTONS - 1));
        o_s_tready  = !r_busy || (w_issue && w_scan_last);
        w_accept    = i_s_tvalid && o_s_tready;

        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_levels = r_levels;
        if (w_accept) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_levels = i_s_tdata[PIN_W-1:0];
        end else if (w_issue) begin
            if (w_scan_last) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end

        n_b_valid   = r_b_valid;
        n_b_idx     = r_b_idx;
        n_b_pressed = r_b_pressed;
        n_b_end     = r_b_end;
        if (w_issue) begin
            n_b_valid   = 1'b1;
            n_b_idx     = r_cnt;
            n_b_pressed = w_pressed[r_cnt];
            n_b_end     = w_scan_last;
        end else if (w_b_adv) begin
            n_b_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_levels    <= n_levels;
        r_b_idx     <= n_b_idx;
        r_b_pressed <= n_b_pressed;
        r_b_end     <= n_b_end;
    end

    bdh_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_cnt),
        .i_wr_en   (w_b_adv),
        .i_wr_addr (r_b_idx),
        .i_wr_data (w_res.entry),
        .o_rd_data (w_rd_data)
    );

    bdh_step u_step (
        .i_entry    (w_rd_data),
        .i_pressed  (r_b_pressed),
        .i_debounce (r_debounce),
        .i_hold     (r_hold),
        .o_res      (w_res)
    );

    assign w_new_evt.idx  = to_out_idx(r_b_idx);
    assign w_new_evt.code = w_res.code;

    bdh_evt_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_b_adv && w_res.ev),
        .i_event    (w_new_evt),
        .i_end      (w_b_adv && r_b_end),
        .o_can_take (w_can_take),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_event    (w_out_evt),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {{(M_TDATA_W - OUT_IDX_W){1'b0}}, w_out_evt.idx};
    assign o_m_tuser = w_out_evt.code;

endmodule
